// ===== sv/tom_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the thermistor monitor.
package tom_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int CH_W = 2;
  localparam int MV_W = 12;
  localparam int LOG_FRAC = 24;
  localparam int LOG_W = 29;

  localparam logic [11:0] VREF_MV = 12'd3300;
  localparam logic [14:0] ZERO_C_CENTIK = 15'd27315;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [6:0] HUNDRED = 7'd100;

  typedef enum logic [2:0] {
    REG_SERIES  = 3'd0,
    REG_NOMINAL = 3'd1,
    REG_T0      = 3'd2,
    REG_BETA    = 3'd3,
    REG_WARN    = 3'd4,
    REG_TRIP    = 3'd5,
    REG_FLOOR   = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOG_START,
    OP_LN,
    OP_LNX,
    OP_CL,
    OP_DEN,
    OP_K,
    OP_P,
    OP_X,
    OP_SAT,
    OP_DIV,
    OP_FIN,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] div_bit;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic den_bad;
    logic log_busy;
    logic out_free;
  } status_t;

endpackage

// ===== sv/thermistor_overtemp_monitor_top.sv =====
// Top level of the NTC thermistor over-temperature monitor.
//  channel | direction | handshake             | payload
//  s       | in        | s_tvalid / s_tready   | s_tdata: divider reading
//  m       | out       | m_tvalid / m_tready   | m_tdata: temperature and flags
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// The time from acceptance of a reading to its output word is set mostly by the
// two logarithm units, which normalize and then square 24 times; an invalid reading skips them.
// A new word is taken only when the previous one has reached the output register.
// Reset restores the default settings and clears all sticky flags.
// A stalled output holds its word and only delays the end of the next reading.
module thermistor_overtemp_monitor_top import tom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel_index[1:0], divider_mv[13:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // channel_id, temperature_c, reading_invalid,
                                 // sensor_warn, sensor_trip, channel_warn, channel_trip
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tom_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .status(status), .cmd(cmd)
  );

  tom_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

// ===== sv/tom_log2.sv =====
// Iterative base-2 logarithm in Q24 of a nonzero 32-bit value.
module tom_log2 import tom_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      value,
  output logic             busy,
  output logic [LOG_W-1:0] result
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} lstate_t;

  lstate_t              state;
  logic [31:0]          w;
  logic [4:0]           e;
  logic [4:0]           k;
  logic [30:0]          m;
  logic [LOG_FRAC-1:0]  frac;
  logic [61:0]          prod;
  logic [31:0]          sq;

  assign prod = 62'(m) * 62'(m);
  assign sq = prod[61:30];
  assign busy = (state != L_IDLE);
  assign result = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            w <= value;
            e <= 5'd31;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (w[31:24] == 8'd0) begin
            w <= w << 8;
            e <= e - 5'd8;
          end else if (!w[31]) begin
            w <= w << 1;
            e <= e - 5'd1;
          end else begin
            m <= w[31:1];
            k <= 5'd0;
            state <= L_SQR;
          end
        end
        L_SQR: begin
          if (sq[31]) begin
            m <= sq[31:1];
            frac <= {frac[LOG_FRAC-2:0], 1'b1};
          end else begin
            m <= sq[30:0];
            frac <= {frac[LOG_FRAC-2:0], 1'b0};
          end
          k <= k + 5'd1;
          if (k == 5'(LOG_FRAC - 1)) begin
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/tom_ctrl.sv =====
// Sequencing state machine of the thermistor monitor.
module tom_ctrl import tom_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_WAIT, S_LN, S_LNX, S_CL, S_DEN, S_K, S_P, S_X, S_SAT,
    S_DIV, S_FIN, S_OUTW
  } state_t;

  state_t     state;
  logic [2:0] k;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    cmd.div_bit = k;
    case (state)
      S_IDLE:  cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
      S_CHK:   cmd.op = status.invalid ? OP_NONE : OP_LOG_START;
      S_LN:    cmd.op = OP_LN;
      S_LNX:   cmd.op = OP_LNX;
      S_CL:    cmd.op = OP_CL;
      S_DEN:   cmd.op = OP_DEN;
      S_K:     cmd.op = OP_K;
      S_P:     cmd.op = OP_P;
      S_X:     cmd.op = OP_X;
      S_SAT:   cmd.op = OP_SAT;
      S_DIV:   cmd.op = OP_DIV;
      S_FIN:   cmd.op = OP_FIN;
      S_OUTW:  cmd.op = status.out_free ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= 3'd0;
    end else begin
      case (state)
        S_IDLE: if (s_tvalid) state <= S_CHK;
        S_CHK:  state <= status.invalid ? S_OUTW : S_WAIT;
        S_WAIT: if (!status.log_busy) state <= S_LN;
        S_LN:   state <= S_LNX;
        S_LNX:  state <= S_CL;
        S_CL:   state <= S_DEN;
        S_DEN:  state <= S_K;
        S_K:    state <= status.den_bad ? S_OUTW : S_P;
        S_P:    state <= S_X;
        S_X:    state <= S_SAT;
        S_SAT: begin
          k <= 3'd7;
          state <= S_DIV;
        end
        S_DIV: begin
          if (k == 3'd0) begin
            state <= S_FIN;
          end else begin
            k <= k - 3'd1;
          end
        end
        S_FIN:  state <= S_OUTW;
        S_OUTW: if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/tom_datapath.sv =====
// Datapath of the thermistor monitor: settings, arithmetic, sticky flags and output word.
module tom_datapath import tom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata
);

  logic [19:0]        series_ohms, nominal_ohms;
  logic [15:0]        nominal_ck;
  logic [13:0]        beta_k;
  logic signed [7:0]  warn_limit, trip_limit, floor_limit;
  logic [19:0]        r0e;
  logic [15:0]        ce;
  logic [13:0]        be;

  logic [CH_W-1:0]    ch;
  logic               invalid;
  logic [31:0]        n, d;
  logic               busy_n, busy_d;
  logic [LOG_W-1:0]   log_n, log_d;
  logic signed [29:0] l;
  logic [28:0]        lmag_in;
  logic               lneg;
  logic [58:0]        lprod;
  logic [59:0]        lround;
  logic signed [30:0] lnx;
  logic [29:0]        cb;
  logic signed [47:0] cl;
  logic [20:0]        nb;
  logic [36:0]        cb100;
  logic signed [47:0] den;
  logic [60:0]        num, kd;
  logic [52:0]        q;
  logic signed [63:0] p;
  logic [62:0]        ap;
  logic               pneg;
  logic [64:0]        x, ys;
  logic [53:0]        y;
  logic               sat;
  logic [7:0]         res;
  logic signed [7:0]  t;
  logic [CHANNEL_COUNT-1:0] warn_flags, trip_flags;
  logic               sw, st, warn_hit, cw, ct;
  logic [11:0]        mv_in;

  assign r0e = (nominal_ohms == 20'd0) ? 20'd1 : nominal_ohms;
  assign ce = (nominal_ck == 16'd0) ? 16'd1 : nominal_ck;
  assign be = (beta_k == 14'd0) ? 14'd1 : beta_k;
  assign mv_in = s_tdata[13:2];

  assign l = $signed({1'b0, log_n}) - $signed({1'b0, log_d});
  assign lmag_in = l[29] ? 29'(-l) : l[28:0];
  assign lround = 60'(lprod) + 60'(1 << 29);
  assign ap = p[63] ? 63'(-p) : p[62:0];
  assign ys = 65'(y) << cmd.div_bit;

  assign sw = (t >= warn_limit);
  assign st = (t >= trip_limit);
  assign warn_hit = sw || (t < floor_limit) || invalid;
  assign cw = warn_flags[ch] | warn_hit;
  assign ct = trip_flags[ch] | st;

  assign status.invalid = invalid;
  assign status.den_bad = den[47] || (den == 48'sd0);
  assign status.log_busy = busy_n | busy_d;
  assign status.out_free = !m_tvalid || m_tready;

  tom_log2 u_log_n (
    .clk(clk), .rst(rst), .start(cmd.op == OP_LOG_START), .value(n),
    .busy(busy_n), .result(log_n)
  );

  tom_log2 u_log_d (
    .clk(clk), .rst(rst), .start(cmd.op == OP_LOG_START), .value(d),
    .busy(busy_d), .result(log_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      series_ohms <= 20'd10000;
      nominal_ohms <= 20'd10000;
      nominal_ck <= 16'd29815;
      beta_k <= 14'd3435;
      warn_limit <= 8'sd70;
      trip_limit <= 8'sd85;
      floor_limit <= -8'sd40;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SERIES:  series_ohms <= cfg_data;
        REG_NOMINAL: nominal_ohms <= cfg_data;
        REG_T0:      nominal_ck <= cfg_data[15:0];
        REG_BETA:    beta_k <= cfg_data[13:0];
        REG_WARN:    warn_limit <= cfg_data[7:0];
        REG_TRIP:    trip_limit <= cfg_data[7:0];
        REG_FLOOR:   floor_limit <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ch <= s_tdata[1:0];
        invalid <= (mv_in == 12'd0) || (mv_in >= VREF_MV) || (series_ohms == 20'd0);
        n <= 32'(series_ohms) * 32'(mv_in);
        d <= 32'(r0e) * 32'(VREF_MV - mv_in);
        t <= -8'sd128;
      end
      OP_LN: begin
        lneg <= l[29];
        lprod <= 59'(lmag_in) * 59'(LN2_Q30);
      end
      OP_LNX: begin
        lnx <= lneg ? -$signed({1'b0, lround[59:30]}) : $signed({1'b0, lround[59:30]});
        cb <= 30'(ce) * 30'(be);
      end
      OP_CL: begin
        cl <= 48'($signed({1'b0, ce}) * lnx);
        nb <= 21'(be) * 21'(HUNDRED);
        cb100 <= 37'(cb) * 37'(HUNDRED);
      end
      OP_DEN: begin
        den <= $signed({3'b000, nb, 24'd0}) + cl;
        num <= {cb100, 24'd0};
      end
      OP_K: begin
        kd <= 61'(den[45:0]) * 61'(ZERO_C_CENTIK);
        q <= 53'(den[45:0]) * 53'(HUNDRED);
      end
      OP_P: p <= $signed({3'b000, num}) - $signed({3'b000, kd});
      OP_X: begin
        pneg <= p[63];
        x <= {1'b0, ap, 1'b0} + 65'(q);
        y <= {q, 1'b0};
      end
      OP_SAT: begin
        sat <= (x >= {3'b000, y, 8'd0});
        res <= 8'd0;
      end
      OP_DIV: begin
        if (x >= ys) begin
          x <= x - ys;
          res[cmd.div_bit] <= 1'b1;
        end
      end
      OP_FIN: begin
        if (pneg) begin
          t <= (sat || res > 8'd128) ? -8'sd128 : $signed(8'(8'd0 - res));
        end else begin
          t <= (sat || res > 8'd127) ? 8'sd127 : $signed(res);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_flags <= '0;
      trip_flags <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        warn_flags[ch] <= cw;
        trip_flags[ch] <= ct;
        m_tvalid <= 1'b1;
        m_tdata <= {1'b0, ct, cw, st, sw, invalid, t, ch};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((trip_flags & $past(trip_flags)) == $past(trip_flags)))
    else $error("Sticky trip flag cleared.");
  a_trip_implies_chan: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12]) |-> m_tdata[14])
    else $error("Sensor trip without channel trip.");
  a_invalid_temp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10]) |-> (m_tdata[9:2] == 8'h80 && m_tdata[13]))
    else $error("Invalid reading with wrong temperature or warning.");
`endif

endmodule

// ===== verif/thermistor_checker.sv =====
// Checker of the thermistor monitor: watches the streams, predicts temperatures and flags.
`timescale 1ns / 1ps
module thermistor_checker import tom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic       chan_trip;
    logic       chan_warn;
    logic       trip;
    logic       warn;
    logic       invalid;
    logic [7:0] temp;
    logic [1:0] chan;
  } reading_t;

  logic [19:0] series_r, nominal_r;
  logic [15:0] t0_r;
  logic [13:0] beta_r;
  logic signed [7:0] warn_r, trip_r, floor_r;
  logic [CHANNEL_COUNT-1:0] warn_sticky, trip_sticky;
  reading_t expected_words[$];

  function automatic longint unsigned log2_fix(longint unsigned v);
    int e;
    longint unsigned m, r;
    e = 63;
    while (v[e] == 1'b0) e--;
    m = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
    r = longint'(e) << 24;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r[23 - i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int beta_temp(int unsigned mv);
    longint r0, c, b, l, lnx, den, num, p, t;
    longint unsigned n, d, mag, q, ap, res;
    r0 = (nominal_r != 0) ? nominal_r : 1;
    c = (t0_r != 0) ? t0_r : 1;
    b = (beta_r != 0) ? beta_r : 1;
    n = longint'(series_r) * mv;
    d = r0 * (3300 - mv);
    l = longint'(log2_fix(n)) - longint'(log2_fix(d));
    mag = (l < 0) ? -l : l;
    mag = (mag * 744261118 + (64'd1 << 29)) >> 30;
    lnx = (l < 0) ? -longint'(mag) : longint'(mag);
    den = 100 * b * 16777216 + c * lnx;
    if (den <= 0) return -128;
    num = c * b * 100 * 16777216;
    p = num - 27315 * den;
    q = 100 * den;
    ap = (p < 0) ? -p : p;
    res = (2 * ap + q) / (2 * q);
    if (p < 0) t = (res > 128) ? -128 : -longint'(res);
    else t = (res > 127) ? 127 : longint'(res);
    return int'(t);
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    reading_t w, got;
    int unsigned mv;
    int t;
    logic [1:0] ch;
    if (rst) begin
      series_r <= 20'd10000;
      nominal_r <= 20'd10000;
      t0_r <= 16'd29815;
      beta_r <= 14'd3435;
      warn_r <= 8'sd70;
      trip_r <= 8'sd85;
      floor_r <= -8'sd40;
      warn_sticky = '0;
      trip_sticky = '0;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SERIES:  series_r <= cfg_data;
          REG_NOMINAL: nominal_r <= cfg_data;
          REG_T0:      t0_r <= cfg_data[15:0];
          REG_BETA:    beta_r <= cfg_data[13:0];
          REG_WARN:    warn_r <= cfg_data[7:0];
          REG_TRIP:    trip_r <= cfg_data[7:0];
          REG_FLOOR:   floor_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        ch = s_tdata[1:0];
        mv = 32'(s_tdata[13:2]);
        w.invalid = (mv == 0) || (mv >= 3300) || (series_r == 0);
        t = w.invalid ? -128 : beta_temp(mv);
        w.warn = t >= int'(warn_r);
        w.trip = t >= int'(trip_r);
        if (w.warn || t < int'(floor_r) || w.invalid) warn_sticky[ch] = 1'b1;
        if (w.trip) trip_sticky[ch] = 1'b1;
        w.chan = ch;
        w.temp = t[7:0];
        w.chan_warn = warn_sticky[ch];
        w.chan_trip = trip_sticky[ch];
        expected_words.push_back(w);
      end
      if (m_tvalid && m_tready) begin
        got = reading_t'(m_tdata[14:0]);
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          w = expected_words.pop_front();
          if (got !== w || m_tdata[15] !== 1'b0) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, {1'b0, w}, m_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the thermistor monitor testbench: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module testbench;
  import tom_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0, s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid, m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  int fail_count, pending;
  longint cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  thermistor_overtemp_monitor_top uut (.*);
  thermistor_checker chk (.*);

  always begin
    @(negedge clk);
    if (!rst) begin
      int gap;
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_reading(input logic [1:0] ch, input logic [11:0] mv);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, mv, ch};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [19:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_readings(input int count);
    logic [11:0] mv;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: mv = 12'($urandom);
        1: mv = 12'($urandom_range(0, 20));
        2: mv = 12'($urandom_range(3280, 3310));
        default: mv = 12'($urandom_range(1, 3299));
      endcase
      send_reading(2'($urandom), mv);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    send_reading(0, 0);
    send_reading(1, 1);
    send_reading(2, 1650);
    send_reading(3, 3299);
    send_reading(0, 3300);
    send_reading(1, 4095);
    send_reading(2, 300);
    send_reading(3, 3000);
    send_reading(0, 12'hAAA);
    send_reading(1, 12'h555);
    send_reading(2, 3200);
    send_reading(3, 100);
    random_readings(300);
    write_reg(REG_SERIES, 20'd1);
    write_reg(REG_NOMINAL, 20'd1000000);
    write_reg(REG_T0, 20'd20000);
    write_reg(REG_BETA, 20'd1);
    write_reg(REG_WARN, 20'h80);
    write_reg(REG_TRIP, 20'h7F);
    write_reg(REG_FLOOR, 20'h7F);
    random_readings(250);
    write_reg(REG_SERIES, 20'd1000000);
    write_reg(REG_NOMINAL, 20'd1);
    write_reg(REG_T0, 20'd40000);
    write_reg(REG_BETA, 20'd10000);
    write_reg(REG_WARN, 20'd0);
    write_reg(REG_TRIP, 20'd50);
    write_reg(REG_FLOOR, 20'h80);
    random_readings(250);
    write_reg(REG_SERIES, 20'd0);
    write_reg(REG_NOMINAL, 20'd0);
    write_reg(REG_T0, 20'd0);
    write_reg(REG_BETA, 20'd0);
    random_readings(100);
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_SERIES, 20'($urandom_range(1, 1000000)));
      write_reg(REG_NOMINAL, 20'($urandom_range(1, 1000000)));
      write_reg(REG_T0, 20'($urandom_range(20000, 40000)));
      write_reg(REG_BETA, 20'($urandom_range(1, 10000)));
      write_reg(REG_WARN, 20'($urandom_range(0, 255)));
      write_reg(REG_TRIP, 20'($urandom_range(0, 255)));
      write_reg(REG_FLOOR, 20'($urandom_range(0, 255)));
      write_reg(cfg_reg_t'(3'd7), 20'($urandom));
      random_readings(150);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tom_pkg.sv
sv/tom_log2.sv
sv/tom_ctrl.sv
sv/tom_datapath.sv
sv/thermistor_overtemp_monitor_top.sv
verif/thermistor_checker.sv
verif/testbench.sv
